/* rtl/core/p1305_pkg.sv */
// ----------------------------------------------------------------------------
// p1305_pkg
// Shared types and constants for the Poly1305 authenticator core.
// ----------------------------------------------------------------------------
package p1305_pkg;

  // Key r clamp mask
  localparam logic [127:0] R_KEY_MASK = 128'h0ffffffc0ffffffc0ffffffc0fffffff;

  // Field widths
  localparam int ACC_W   = 130;            // accumulator, below 2^130-5
  localparam int SUM_W   = 131;            // accumulator plus padded block
  localparam int MSG_W   = 129;            // padded block, below 2^129
  localparam int RKEY_W  = 124;            // clamped r has bits 123..0
  localparam int PROD_W  = SUM_W + RKEY_W; // full product width

  // Limb split for the shared multiplier
  localparam int XLIMB_W = 27;
  localparam int XLIMBS  = 5;
  localparam int RLIMB_W = 31;
  localparam int RLIMBS  = 4;
  localparam int PP_W    = XLIMB_W + RLIMB_W;
  localparam int SHIFT_W = 8;

  // Reduction constant: 2^130 = 5 mod p
  localparam int FOLD_K  = 5;

  // Byte count for a full block
  localparam logic [4:0] FULL_COUNT = 5'd16;

  // Key register map
  typedef enum logic [1:0] {
    REG_R_LOW,
    REG_R_HIGH,
    REG_S_LOW,
    REG_S_HIGH
  } key_reg_t;

  // Block descriptor passed from front to back
  typedef struct packed {
    logic [MSG_W-1:0] msg;
    logic             absorb;
    logic             last;
  } blk_item_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_DRAIN,
    B_FOLD1,
    B_FOLD2,
    B_FINAL,
    B_TAG
  } back_state_t;

endpackage

/* rtl/core/poly1305_mac.sv */
// ----------------------------------------------------------------------------
// poly1305_mac
// Poly1305 one-time authenticator: queued block input, tag output queue.
// ----------------------------------------------------------------------------
// Each absorbed block runs through the accumulator loop on the shared 27x31
//   multiplier (20 partial products plus reduction) before the next block
//   is taken from the queue.
// The tag is pushed from the TAG state, after the last block's reduction, or
//   straight from idle for a final beat with a zero count.
// Input beats are taken every cycle while the block queue has room.
// Reset (rst, synchronous): clears keys, accumulator and both queues.
// ----------------------------------------------------------------------------
module poly1305_mac #(
  parameter int IN_DEPTH  = 4,
  parameter int OUT_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  // block input
  input  logic        push,
  output logic        full,
  input  logic [63:0] block_low,
  input  logic [63:0] block_high,
  input  logic [4:0]  byte_count,
  input  logic        last,
  // tag output
  output logic        empty,
  input  logic        pop,
  output logic [63:0] tag_low,
  output logic [63:0] tag_high,
  // configuration
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int ITEM_W = $bits(p1305_pkg::blk_item_t);

  logic [63:0] r_low;
  logic [63:0] r_high;
  logic [63:0] s_low;
  logic [63:0] s_high;
  logic [127:0] rclamp;

  p1305_pkg::blk_item_t fe_item;
  p1305_pkg::blk_item_t be_item;
  logic [ITEM_W-1:0]    be_bits;
  logic                 fe_push;
  logic                 q_full;
  logic                 q_empty;
  logic                 q_pop;
  logic                 out_full;
  logic                 out_push;
  logic [127:0]         tag;
  logic [127:0]         tag_q;

  // key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      r_low  <= '0;
      r_high <= '0;
      s_low  <= '0;
      s_high <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        p1305_pkg::REG_R_LOW:  r_low  <= cfg_data;
        p1305_pkg::REG_R_HIGH: r_high <= cfg_data;
        p1305_pkg::REG_S_LOW:  s_low  <= cfg_data;
        p1305_pkg::REG_S_HIGH: s_high <= cfg_data;
        default:               r_low  <= r_low;
      endcase
    end
  end

  assign rclamp = {r_high, r_low} & p1305_pkg::R_KEY_MASK;

  // front: pad and classify
  p1305_front u_front (
    .push       (push),
    .full       (full),
    .block_low  (block_low),
    .block_high (block_high),
    .byte_count (byte_count),
    .last       (last),
    .q_full     (q_full),
    .q_push     (fe_push),
    .q_item     (fe_item)
  );

  // block queue between front and back
  p1305_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (IN_DEPTH)
  ) u_blk_q (
    .clk   (clk),
    .rst   (rst),
    .push  (fe_push),
    .din   (fe_item),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (be_bits),
    .empty (q_empty)
  );

  assign be_item = p1305_pkg::blk_item_t'(be_bits);

  // back: multiply, reduce, finish
  p1305_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_item   (be_item),
    .q_pop    (q_pop),
    .rkey     (rclamp[p1305_pkg::RKEY_W-1:0]),
    .skey     ({s_high, s_low}),
    .out_full (out_full),
    .out_push (out_push),
    .tag      (tag)
  );

  // tag queue
  p1305_fifo #(
    .WIDTH (128),
    .DEPTH (OUT_DEPTH)
  ) u_tag_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .din   (tag),
    .full  (out_full),
    .pop   (pop),
    .dout  (tag_q),
    .empty (empty)
  );

  assign tag_low  = tag_q[63:0];
  assign tag_high = tag_q[127:64];

endmodule

/* rtl/core/p1305_fifo.sv */
// ----------------------------------------------------------------------------
// p1305_fifo
// Small show-ahead FIFO in flip-flops; head entry is visible while not empty.
// ----------------------------------------------------------------------------
module p1305_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  // handshake
  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= din;
    end
  end

endmodule

/* rtl/core/p1305_front.sv */
// ----------------------------------------------------------------------------
// p1305_front
// Input beat classification: masks bytes past the count, appends the pad bit,
// and drops beats that neither absorb data nor finish a message.
// ----------------------------------------------------------------------------
module p1305_front (
  input  logic                  push,
  output logic                  full,
  input  logic [63:0]           block_low,
  input  logic [63:0]           block_high,
  input  logic [4:0]            byte_count,
  input  logic                  last,
  input  logic                  q_full,
  output logic                  q_push,
  output p1305_pkg::blk_item_t  q_item
);

  logic [4:0]   cnt;
  logic [127:0] data;
  logic [128:0] msg;

  // clamp count to a full block
  assign cnt  = (byte_count > p1305_pkg::FULL_COUNT) ? p1305_pkg::FULL_COUNT : byte_count;
  assign data = {block_high, block_low};

  // byte mask and pad bit at 8*count
  always_comb begin
    msg = '0;
    for (int b = 0; b < 16; b++) begin
      if (5'(b) < cnt) begin
        msg[8*b +: 8] = data[8*b +: 8];
      end
    end
    for (int k = 1; k <= 16; k++) begin
      if (cnt == 5'(k)) begin
        msg[8*k] = 1'b1;
      end
    end
  end

  // descriptor into the queue
  always_comb begin
    q_item.msg    = msg;
    q_item.absorb = (cnt != '0);
    q_item.last   = last;
  end

  assign full   = q_full;
  assign q_push = push && !q_full && (q_item.absorb || q_item.last);

endmodule

/* rtl/core/p1305_back.sv */
// ----------------------------------------------------------------------------
// p1305_back
// Block engine: accumulator add, multiply by r over a shared 27x31 multiplier,
// reduction modulo 2^130-5, and tag finish (acc + s) mod 2^128.
// ----------------------------------------------------------------------------
module p1305_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_empty,
  input  p1305_pkg::blk_item_t                 q_item,
  output logic                                 q_pop,
  input  logic [p1305_pkg::RKEY_W-1:0]         rkey,
  input  logic [127:0]                         skey,
  input  logic                                 out_full,
  output logic                                 out_push,
  output logic [127:0]                         tag
);

  localparam int XPAD_W = p1305_pkg::XLIMB_W * p1305_pkg::XLIMBS;

  p1305_pkg::back_state_t state;
  p1305_pkg::back_state_t state_next;

  logic [p1305_pkg::ACC_W-1:0]   acc;
  logic                          item_last;
  logic [p1305_pkg::SUM_W-1:0]   xsum;
  logic [XPAD_W-1:0]             xpad;
  logic [2:0]                    li;
  logic [1:0]                    lj;
  logic [p1305_pkg::XLIMB_W-1:0] xl;
  logic [p1305_pkg::RLIMB_W-1:0] rl;
  logic [p1305_pkg::PP_W-1:0]    preg;
  logic [p1305_pkg::SHIFT_W-1:0] pshift;
  logic                          pvalid;
  logic [p1305_pkg::PROD_W-1:0]  prod;
  logic [p1305_pkg::PROD_W-p1305_pkg::ACC_W-1:0] phi;
  logic [p1305_pkg::SUM_W-1:0]   fold;
  logic [p1305_pkg::SUM_W-1:0]   fold_g;
  logic                          mul_done;

  // limb selection for the multiplier
  assign xpad     = XPAD_W'(xsum);
  assign xl       = xpad[li*p1305_pkg::XLIMB_W +: p1305_pkg::XLIMB_W];
  assign rl       = rkey[lj*p1305_pkg::RLIMB_W +: p1305_pkg::RLIMB_W];
  assign mul_done = (li == 3'(p1305_pkg::XLIMBS - 1)) && (lj == 2'(p1305_pkg::RLIMBS - 1));
  assign phi      = prod[p1305_pkg::PROD_W-1:p1305_pkg::ACC_W];
  assign fold_g   = fold + p1305_pkg::SUM_W'(p1305_pkg::FOLD_K);
  assign tag      = acc[127:0] + skey;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      p1305_pkg::B_IDLE: begin
        if (!q_empty) begin
          if (q_item.absorb) begin
            state_next = p1305_pkg::B_MUL;
          end else if (q_item.last) begin
            state_next = p1305_pkg::B_TAG;
          end
        end
      end
      p1305_pkg::B_MUL: begin
        if (mul_done) begin
          state_next = p1305_pkg::B_DRAIN;
        end
      end
      p1305_pkg::B_DRAIN: state_next = p1305_pkg::B_FOLD1;
      p1305_pkg::B_FOLD1: state_next = p1305_pkg::B_FOLD2;
      p1305_pkg::B_FOLD2: state_next = p1305_pkg::B_FINAL;
      p1305_pkg::B_FINAL: begin
        state_next = item_last ? p1305_pkg::B_TAG : p1305_pkg::B_IDLE;
      end
      p1305_pkg::B_TAG: begin
        if (!out_full) begin
          state_next = p1305_pkg::B_IDLE;
        end
      end
      default: state_next = p1305_pkg::B_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    q_pop    = 1'b0;
    out_push = 1'b0;
    case (state)
      p1305_pkg::B_IDLE: q_pop    = !q_empty;
      p1305_pkg::B_TAG:  out_push = !out_full;
      default: begin
        q_pop    = 1'b0;
        out_push = 1'b0;
      end
    endcase
  end

  // control state and accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= p1305_pkg::B_IDLE;
      pvalid <= 1'b0;
      acc    <= '0;
      li     <= '0;
      lj     <= '0;
    end else begin
      state  <= state_next;
      pvalid <= (state == p1305_pkg::B_MUL);
      case (state)
        p1305_pkg::B_IDLE: begin
          li <= '0;
          lj <= '0;
        end
        p1305_pkg::B_MUL: begin
          if (lj == 2'(p1305_pkg::RLIMBS - 1)) begin
            lj <= '0;
            li <= li + 3'd1;
          end else begin
            lj <= lj + 2'd1;
          end
        end
        p1305_pkg::B_FINAL: begin
          acc <= fold_g[p1305_pkg::ACC_W] ? fold_g[p1305_pkg::ACC_W-1:0]
                                          : fold[p1305_pkg::ACC_W-1:0];
        end
        p1305_pkg::B_TAG: begin
          if (!out_full) begin
            acc <= '0;
          end
        end
        default: acc <= acc;
      endcase
    end
  end

  // datapath: operand capture, partial products, product sum, folding
  always_ff @(posedge clk) begin
    if (state == p1305_pkg::B_IDLE && !q_empty) begin
      item_last <= q_item.last;
      xsum      <= p1305_pkg::SUM_W'(acc) + p1305_pkg::SUM_W'(q_item.msg);
    end

    // one 27x31 partial product per cycle
    preg   <= p1305_pkg::PP_W'(xl) * p1305_pkg::PP_W'(rl);
    pshift <= p1305_pkg::SHIFT_W'(li) * p1305_pkg::SHIFT_W'(p1305_pkg::XLIMB_W)
            + p1305_pkg::SHIFT_W'(lj) * p1305_pkg::SHIFT_W'(p1305_pkg::RLIMB_W);

    // shifted accumulate of the registered product
    if (state == p1305_pkg::B_IDLE) begin
      prod <= '0;
    end else if (pvalid) begin
      prod <= prod + (p1305_pkg::PROD_W'(preg) << pshift);
    end

    // 2^130 = 5: fold high part twice
    if (state == p1305_pkg::B_FOLD1) begin
      fold <= p1305_pkg::SUM_W'(prod[p1305_pkg::ACC_W-1:0])
            + p1305_pkg::SUM_W'({phi, 2'b00})
            + p1305_pkg::SUM_W'(phi);
    end else if (state == p1305_pkg::B_FOLD2) begin
      fold <= p1305_pkg::SUM_W'(fold[p1305_pkg::ACC_W-1:0])
            + (fold[p1305_pkg::ACC_W] ? p1305_pkg::SUM_W'(p1305_pkg::FOLD_K) : '0);
    end
  end

endmodule
